// File: hw/rtl/kwm_pkg.sv
// Shared constants for the k-way merge heap selector.
package kwm_pkg;

  localparam int unsigned MAX_SOURCES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF    = 64;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned SRC_PORT_W = 4;
  localparam int unsigned KEY_PORT_W = 64;
  localparam int unsigned ACT_W      = 5;

  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REPLACE = 2'd2;

endpackage

// File: hw/rtl/kwm_ram.sv
// Single write port, single registered read port memory.
module kwm_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/k_way_merge_heap_selector.sv
// Top level of the k-way merge heap selector: sequencer, shared comparator, heap memories.
//
// An item is taken when start_i is high and busy_o is low; busy_o then stays high until the
// result is issued. done_o is high for exactly one cycle, in the first cycle with busy_o low
// again, and the top_* ports hold the result until the next one; the receiver cannot stall
// it, and a new item may be started in that same cycle. Clear, an unused op code and an
// ignored load or replace go straight to the finish state. A load passes read, key and
// compare states for each parent compare while the new head climbs (at most 4 with 16
// sources), and a last read state when it reaches the top. A replace passes read, two fetch,
// select and compare states for each level whose children are compared, without select where
// the level has a single child, and a last read state where the head settles with no child.
// Each step waits its turn for the one comparator shared by every step and for the single
// read port of the heap order and head key memories, which are read one entry a cycle.
module k_way_merge_heap_selector #(
  parameter int unsigned MAX_SOURCES = kwm_pkg::MAX_SOURCES_DEF,
  parameter int unsigned KEY_BITS    = kwm_pkg::KEY_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kwm_pkg::ACT_W-1:0]       cfg_wdata_i,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [kwm_pkg::OP_W-1:0]        op_i,
  input  logic [kwm_pkg::SRC_PORT_W-1:0]  source_i,
  input  logic [kwm_pkg::KEY_PORT_W-1:0]  key_i,
  input  logic                            more_i,
  output logic                            done_o,
  output logic [kwm_pkg::SRC_PORT_W-1:0]  top_source_o,
  output logic [kwm_pkg::KEY_PORT_W-1:0]  top_key_o,
  output logic                            top_live_o
);
  import kwm_pkg::*;

  localparam int unsigned SRC_W  = $clog2(MAX_SOURCES);
  localparam int unsigned PW     = $clog2(MAX_SOURCES);
  localparam int unsigned CW     = PW + 2;
  localparam int unsigned FILL_W = $clog2(MAX_SOURCES + 1);
  localparam int unsigned CMP_W  = 10;
  localparam int unsigned ACT_RST_I = (MAX_SOURCES < 16) ? MAX_SOURCES : 16;
  localparam int unsigned ACT_CAP_I = (MAX_SOURCES < 31) ? MAX_SOURCES : 31;
  localparam logic [ACT_W-1:0]  ACT_RST = ACT_W'(ACT_RST_I);
  localparam logic [ACT_W:0]    ACT_CAP = (ACT_W + 1)'(ACT_CAP_I);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_SOURCES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_KEY,
    ST_UP_CMP,
    ST_DN_RD,
    ST_DN_A,
    ST_DN_B,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_FINISH
  } state_e;

  state_e                 state_q;
  logic [ACT_W-1:0]       act_q;
  logic [FILL_W-1:0]      fill_q;
  logic [MAX_SOURCES-1:0] live_q;
  logic [MAX_SOURCES-1:0] inheap_q;
  logic [SRC_W-1:0]       e_src_q;
  logic [KEY_BITS-1:0]    e_key_q;
  logic [PW-1:0]          pos_q;
  logic [CW-1:0]          child_q;
  logic [SRC_W-1:0]       a_src_q;
  logic [KEY_BITS-1:0]    a_key_q;
  logic [SRC_W-1:0]       b_src_q;
  logic [SRC_W-1:0]       best_src_q;
  logic [KEY_BITS-1:0]    best_key_q;
  logic [SRC_W-1:0]       top_src_q;
  logic [KEY_BITS-1:0]    top_key_q;
  logic                   done_q;
  logic [SRC_PORT_W-1:0]  out_src_q;
  logic [KEY_PORT_W-1:0]  out_key_q;
  logic                   out_live_q;

  logic [SRC_W-1:0]       src_in;
  logic [KEY_BITS-1:0]    key_in;
  logic                   load_ok;
  logic [PW-1:0]          parent_w;
  logic [CW-1:0]          child_w;
  logic [CW-1:0]          child_nx;
  logic [CW-1:0]          fill_ext;

  logic                   ord_we;
  logic [SRC_W-1:0]       ord_wdata;
  logic [KEY_BITS-1:0]    ord_wkey;
  logic [PW-1:0]          ord_raddr;
  logic [SRC_W-1:0]       ord_rdata;
  logic                   key_we;
  logic [KEY_BITS-1:0]    key_rdata;

  logic [SRC_W-1:0]       x_src;
  logic [KEY_BITS-1:0]    x_key;
  logic [SRC_W-1:0]       y_src;
  logic [KEY_BITS-1:0]    y_key;
  logic                   x_live;
  logic                   y_live;
  logic                   x_first;

  assign src_in   = SRC_W'(source_i);
  assign key_in   = key_i[KEY_BITS-1:0];
  assign parent_w = PW'((pos_q - PW'(1)) >> 1);
  assign child_w  = {1'b0, pos_q, 1'b1};
  assign child_nx = child_q + CW'(1);
  assign fill_ext = CW'(fill_q);

  assign load_ok = (CMP_W'(source_i) < CMP_W'(act_q)) && (CMP_W'(fill_q) < CMP_W'(act_q)) &&
                   (fill_q < FILL_MAX) && !inheap_q[src_in];

  // shared comparator: does x go before y
  always_comb begin
    x_src = best_src_q;
    x_key = best_key_q;
    y_src = e_src_q;
    y_key = e_key_q;
    unique case (state_q)
      ST_UP_CMP: begin
        x_src = e_src_q;
        x_key = e_key_q;
        y_src = a_src_q;
        y_key = key_rdata;
      end
      ST_DN_SEL: begin
        x_src = b_src_q;
        x_key = key_rdata;
        y_src = a_src_q;
        y_key = a_key_q;
      end
      default: ;
    endcase
    x_live = live_q[x_src];
    y_live = live_q[y_src];
    if (x_live != y_live) begin
      x_first = x_live;
    end else if (x_live && (x_key != y_key)) begin
      x_first = x_key < y_key;
    end else begin
      x_first = x_src < y_src;
    end
  end

  always_comb begin
    ord_we    = 1'b0;
    ord_wdata = e_src_q;
    ord_wkey  = e_key_q;
    ord_raddr = parent_w;
    unique case (state_q)
      ST_UP_RD: begin
        ord_we = (pos_q == '0);
      end
      ST_UP_CMP: begin
        ord_we = 1'b1;
        if (x_first) begin
          ord_wdata = a_src_q;
          ord_wkey  = key_rdata;
        end
      end
      ST_DN_RD: begin
        ord_we    = (child_w >= fill_ext);
        ord_raddr = child_w[PW-1:0];
      end
      ST_DN_A: begin
        ord_raddr = child_nx[PW-1:0];
      end
      ST_DN_CMP: begin
        ord_we = 1'b1;
        if (x_first) begin
          ord_wdata = best_src_q;
          ord_wkey  = best_key_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    key_we = 1'b0;
    if (state_q == ST_IDLE && start_i) begin
      priority if (op_i == OP_LOAD) begin
        key_we = load_ok;
      end else if (op_i == OP_REPLACE) begin
        key_we = (fill_q != '0);
      end
    end
  end

  kwm_ram #(
    .DEPTH(MAX_SOURCES),
    .WIDTH(SRC_W)
  ) u_order_ram (
    .clk_i  (clk_i),
    .we_i   (ord_we),
    .waddr_i(pos_q),
    .wdata_i(ord_wdata),
    .raddr_i(ord_raddr),
    .rdata_o(ord_rdata)
  );

  kwm_ram #(
    .DEPTH(MAX_SOURCES),
    .WIDTH(KEY_BITS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i((op_i == OP_LOAD) ? src_in : top_src_q),
    .wdata_i(key_in),
    .raddr_i(ord_rdata),
    .rdata_o(key_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      act_q      <= ACT_RST;
      fill_q     <= '0;
      live_q     <= '0;
      inheap_q   <= '0;
      done_q     <= 1'b0;
      top_src_q  <= '0;
      top_key_q  <= '0;
      e_src_q    <= '0;
      e_key_q    <= '0;
      pos_q      <= '0;
      child_q    <= '0;
      a_src_q    <= '0;
      a_key_q    <= '0;
      b_src_q    <= '0;
      best_src_q <= '0;
      best_key_q <= '0;
      out_src_q  <= '0;
      out_key_q  <= '0;
      out_live_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        priority if (cfg_wdata_i == '0) begin
          act_q <= ACT_W'(1);
        end else if ({1'b0, cfg_wdata_i} > ACT_CAP) begin
          act_q <= ACT_CAP[ACT_W-1:0];
        end else begin
          act_q <= cfg_wdata_i;
        end
      end
      if (ord_we && pos_q == '0) begin
        top_src_q <= ord_wdata;
        top_key_q <= ord_wkey;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_FINISH;
            unique case (op_i)
              OP_CLEAR: begin
                fill_q   <= '0;
                live_q   <= '0;
                inheap_q <= '0;
              end
              OP_LOAD: begin
                if (load_ok) begin
                  live_q[src_in]   <= more_i;
                  inheap_q[src_in] <= 1'b1;
                  e_src_q          <= src_in;
                  e_key_q          <= key_in;
                  pos_q            <= PW'(fill_q);
                  fill_q           <= fill_q + FILL_W'(1);
                  state_q          <= ST_UP_RD;
                end
              end
              OP_REPLACE: begin
                if (fill_q != '0) begin
                  live_q[top_src_q] <= more_i;
                  e_src_q           <= top_src_q;
                  e_key_q           <= key_in;
                  pos_q             <= '0;
                  state_q           <= ST_DN_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_UP_RD: begin
          state_q <= (pos_q == '0) ? ST_FINISH : ST_UP_KEY;
        end
        ST_UP_KEY: begin
          a_src_q <= ord_rdata;
          state_q <= ST_UP_CMP;
        end
        ST_UP_CMP: begin
          if (x_first) begin
            pos_q   <= parent_w;
            state_q <= ST_UP_RD;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_DN_RD: begin
          child_q <= child_w;
          state_q <= (child_w >= fill_ext) ? ST_FINISH : ST_DN_A;
        end
        ST_DN_A: begin
          a_src_q <= ord_rdata;
          state_q <= ST_DN_B;
        end
        ST_DN_B: begin
          a_key_q <= key_rdata;
          b_src_q <= ord_rdata;
          if (child_nx < fill_ext) begin
            state_q <= ST_DN_SEL;
          end else begin
            best_src_q <= a_src_q;
            best_key_q <= key_rdata;
            state_q    <= ST_DN_CMP;
          end
        end
        ST_DN_SEL: begin
          if (x_first) begin
            best_src_q <= b_src_q;
            best_key_q <= key_rdata;
            child_q    <= child_nx;
          end else begin
            best_src_q <= a_src_q;
            best_key_q <= a_key_q;
          end
          state_q <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (x_first) begin
            pos_q   <= child_q[PW-1:0];
            state_q <= ST_DN_RD;
          end else begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done_q <= 1'b1;
          if (fill_q != '0) begin
            out_src_q  <= SRC_PORT_W'(top_src_q);
            out_key_q  <= KEY_PORT_W'(top_key_q);
            out_live_q <= live_q[top_src_q];
          end else begin
            out_src_q  <= '0;
            out_key_q  <= '0;
            out_live_q <= 1'b0;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign top_source_o = out_src_q;
  assign top_key_o    = out_key_q;
  assign top_live_o   = out_live_q;

endmodule

// File: test/kwm_heap_checker.sv
// Checker for the k-way merge heap selector: predicts the top after every item and compares.
module kwm_heap_checker
  import kwm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [ACT_W-1:0]      cfg_wdata_i,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic [OP_W-1:0]       op_i,
  input  logic [SRC_PORT_W-1:0] source_i,
  input  logic [KEY_PORT_W-1:0] key_i,
  input  logic                  more_i,
  input  logic                  done_i,
  input  logic [SRC_PORT_W-1:0] top_source_i,
  input  logic [KEY_PORT_W-1:0] top_key_i,
  input  logic                  top_live_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSRC = MAX_SOURCES_DEF;

  typedef struct packed {
    logic [SRC_PORT_W-1:0] src;
    logic [KEY_PORT_W-1:0] key;
    logic                  live;
  } heap_top_t;

  logic [SRC_PORT_W-1:0] src_in_slot [NSRC];
  logic [KEY_PORT_W-1:0] head_key    [NSRC];
  logic                  head_live   [NSRC];
  int unsigned           heap_size;
  int unsigned           active_srcs;
  heap_top_t             expected_tops [$];
  heap_top_t             want;

  function automatic bit ranks_ahead(input logic [SRC_PORT_W-1:0] a,
                                     input logic [SRC_PORT_W-1:0] b);
    if (head_live[a] != head_live[b]) return head_live[a];
    if (head_live[a] && head_key[a] != head_key[b]) return head_key[a] < head_key[b];
    return a < b;
  endfunction

  function automatic void exchange_slots(input int unsigned i, input int unsigned j);
    logic [SRC_PORT_W-1:0] t;
    t = src_in_slot[i];
    src_in_slot[i] = src_in_slot[j];
    src_in_slot[j] = t;
  endfunction

  function automatic void climb(input int unsigned pos);
    int unsigned parent;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!ranks_ahead(src_in_slot[pos], src_in_slot[parent])) break;
      exchange_slots(pos, parent);
      pos = parent;
    end
  endfunction

  function automatic void sink_top();
    int unsigned parent;
    int unsigned child;
    parent = 0;
    child  = 1;
    while (child < heap_size) begin
      if (child + 1 < heap_size && ranks_ahead(src_in_slot[child + 1], src_in_slot[child]))
        child++;
      if (!ranks_ahead(src_in_slot[child], src_in_slot[parent])) break;
      exchange_slots(parent, child);
      parent = child;
      child  = 2 * parent + 1;
    end
  endfunction

  function automatic heap_top_t merge_step(input logic [OP_W-1:0] op,
                                           input logic [SRC_PORT_W-1:0] src,
                                           input logic [KEY_PORT_W-1:0] key,
                                           input logic more);
    bit        ok;
    heap_top_t res;
    case (op)
      OP_CLEAR: begin
        heap_size = 0;
        foreach (head_live[i]) head_live[i] = 1'b0;
      end
      OP_LOAD: begin
        ok = src < active_srcs && heap_size < active_srcs && heap_size < NSRC;
        for (int unsigned i = 0; i < heap_size; i++)
          if (src_in_slot[i] == src) ok = 1'b0;
        if (ok) begin
          head_key[src]          = key;
          head_live[src]         = more;
          src_in_slot[heap_size] = src;
          heap_size++;
          climb(heap_size - 1);
        end
      end
      OP_REPLACE: begin
        if (heap_size > 0) begin
          head_key[src_in_slot[0]]  = key;
          head_live[src_in_slot[0]] = more;
          sink_top();
        end
      end
      default: ;
    endcase
    res = '0;
    if (heap_size > 0) begin
      res.src  = src_in_slot[0];
      res.key  = head_key[src_in_slot[0]];
      res.live = head_live[src_in_slot[0]];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (src_in_slot[i]) begin
        src_in_slot[i] = '0;
        head_key[i]    = '0;
        head_live[i]   = 1'b0;
      end
      heap_size    = 0;
      active_srcs  = NSRC;
      expected_tops.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == 0) active_srcs = 1;
        else if (cfg_wdata_i > NSRC) active_srcs = NSRC;
        else active_srcs = cfg_wdata_i;
      end
      if (done_i) begin
        if (expected_tops.size() == 0) begin
          $error("result with no item waiting: top_source %0d top_key %h top_live %0b",
                 top_source_i, top_key_i, top_live_i);
          fail_count_o++;
        end else begin
          want = expected_tops.pop_front();
          checked_o++;
          if (top_source_i !== want.src) begin
            $error("top_source: expected %0d, actual %0d", want.src, top_source_i);
            fail_count_o++;
          end
          if (top_key_i !== want.key) begin
            $error("top_key: expected %h, actual %h", want.key, top_key_i);
            fail_count_o++;
          end
          if (top_live_i !== want.live) begin
            $error("top_live: expected %0b, actual %0b", want.live, top_live_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i)
        expected_tops.push_back(merge_step(op_i, source_i, key_i, more_i));
      pending_o = expected_tops.size();
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench top for the k-way merge heap selector: stimulus, watchdog and verdict.
module tb_top;
  import kwm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned     NSRC      = MAX_SOURCES_DEF;
  localparam int unsigned     IDLE_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [ACT_W-1:0]      cfg_wdata;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       op;
  logic [SRC_PORT_W-1:0] source;
  logic [KEY_PORT_W-1:0] key;
  logic                  more;
  logic                  done;
  logic [SRC_PORT_W-1:0] top_source;
  logic [KEY_PORT_W-1:0] top_key;
  logic                  top_live;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           checked;

  int unsigned items_sent;
  int unsigned settings_used;
  int unsigned items_left;
  int unsigned idle_pct;
  int unsigned cur_active;

  k_way_merge_heap_selector i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .start_i     (start),
    .busy_o      (busy),
    .op_i        (op),
    .source_i    (source),
    .key_i       (key),
    .more_i      (more),
    .done_o      (done),
    .top_source_o(top_source),
    .top_key_o   (top_key),
    .top_live_o  (top_live)
  );

  kwm_heap_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .start_i     (start),
    .busy_i      (busy),
    .op_i        (op),
    .source_i    (source),
    .key_i       (key),
    .more_i      (more),
    .done_i      (done),
    .top_source_i(top_source),
    .top_key_i   (top_key),
    .top_live_i  (top_live),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (start && !busy) || done) idle = 0;
      else idle++;
    end
    $display("watchdog: %0d cycles without an item or a result", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(input logic [OP_W-1:0] o, input logic [SRC_PORT_W-1:0] s,
                       input logic [KEY_PORT_W-1:0] k, input logic m);
    start  <= 1'b1;
    op     <= o;
    source <= s;
    key    <= k;
    more   <= m;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic maybe_idle();
    int unsigned gap;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_active(input logic [ACT_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_active = (v == 0) ? 1 : ((v > NSRC) ? NSRC : v);
    settings_used++;
  endtask

  function automatic logic [KEY_PORT_W-1:0] pick_key(input int unsigned style);
    case (style)
      0: return KEY_PORT_W'($urandom_range(0, 3));
      1: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return '1;
          2: return {1'b1, {(KEY_PORT_W - 1){1'b0}}};
          3: return {1'b0, {(KEY_PORT_W - 1){1'b1}}};
          default: return {$urandom, $urandom};
        endcase
      end
    endcase
  endfunction

  // Slip in a stray item now and then; these do not count against items_left.
  task automatic step(input logic [OP_W-1:0] o, input logic [SRC_PORT_W-1:0] s,
                      input logic [KEY_PORT_W-1:0] k, input logic m);
    if ($urandom_range(0, 99) < 6) begin
      maybe_idle();
      if ($urandom_range(0, 1) == 0)
        issue(OP_UNUSED, SRC_PORT_W'($urandom), {$urandom, $urandom}, 1'($urandom));
      else
        issue(OP_LOAD, SRC_PORT_W'($urandom), pick_key(2), 1'($urandom));
    end
    maybe_idle();
    issue(o, s, k, m);
    if (items_left > 0) items_left--;
  endtask

  task automatic merge_round();
    logic [SRC_PORT_W-1:0] order [NSRC];
    logic [SRC_PORT_W-1:0] t;
    logic [SRC_PORT_W-1:0] s;
    int unsigned j;
    int unsigned loads;
    int unsigned repls;
    int unsigned style;
    int unsigned live_pct;
    for (int unsigned i = 0; i < NSRC; i++) order[i] = SRC_PORT_W'(i);
    for (int unsigned i = cur_active - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    style = $urandom_range(0, 2);
    case ($urandom_range(0, 2))
      0: live_pct = 95;
      1: live_pct = 70;
      default: live_pct = 30;
    endcase
    if ($urandom_range(0, 4) != 0)
      step(OP_CLEAR, SRC_PORT_W'($urandom), {$urandom, $urandom}, 1'($urandom));
    loads = $urandom_range(1, cur_active);
    for (int unsigned i = 0; i < loads && items_left > 0; i++) begin
      s = ($urandom_range(0, 99) < 8) ? SRC_PORT_W'($urandom) : order[i];
      step(OP_LOAD, s, pick_key(style), $urandom_range(0, 99) < live_pct);
    end
    repls = $urandom_range(1, 3 * loads + 4);
    for (int unsigned i = 0; i < repls && items_left > 0; i++)
      step(OP_REPLACE, SRC_PORT_W'($urandom), pick_key(style),
           $urandom_range(0, 99) < live_pct);
    if ($urandom_range(0, 11) == 0) drain();
  endtask

  initial begin
    logic [ACT_W-1:0] phase_cfg [9];
    phase_cfg = '{5'd16, 5'd3, 5'd1, 5'd17, 5'd8, 5'd2, 5'd12, 5'd31, 5'd5};
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    start         = 1'b0;
    op            = OP_CLEAR;
    source        = '0;
    key           = '0;
    more          = 1'b0;
    items_sent    = 0;
    settings_used = 0;
    items_left    = 0;
    idle_pct      = 0;
    cur_active    = NSRC;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    issue(OP_REPLACE, 4'd0, 64'd123, 1'b1);
    issue(OP_UNUSED, 4'd5, '1, 1'b1);
    issue(OP_LOAD, 4'd15, '1, 1'b1);
    issue(OP_LOAD, 4'd0, '0, 1'b1);
    issue(OP_LOAD, 4'd0, 64'd77, 1'b1);
    issue(OP_LOAD, 4'd7, '0, 1'b1);
    issue(OP_LOAD, 4'd3, '0, 1'b0);
    issue(OP_LOAD, 4'd9, '1, 1'b0);
    issue(OP_REPLACE, 4'd0, '1, 1'b0);
    issue(OP_REPLACE, 4'd0, 64'h8000_0000_0000_0000, 1'b1);
    issue(OP_UNUSED, 4'd0, '0, 1'b0);
    issue(OP_CLEAR, 4'd15, '1, 1'b1);
    issue(OP_REPLACE, 4'd3, 64'd5, 1'b1);
    write_active(5'd2);
    issue(OP_LOAD, 4'd2, 64'd5, 1'b1);
    issue(OP_LOAD, 4'd1, 64'd9, 1'b1);
    issue(OP_LOAD, 4'd0, 64'd9, 1'b1);
    issue(OP_LOAD, 4'd0, 64'd1, 1'b1);
    write_active(5'd1);
    issue(OP_REPLACE, 4'd0, 64'd20, 1'b1);
    issue(OP_REPLACE, 4'd0, 64'd1, 1'b0);
    issue(OP_LOAD, 4'd0, 64'd2, 1'b1);
    write_active(5'd0);
    issue(OP_CLEAR, 4'd0, '0, 1'b0);
    issue(OP_LOAD, 4'd0, 64'd42, 1'b1);
    issue(OP_LOAD, 4'd1, 64'd3, 1'b1);
    write_active(5'd31);
    issue(OP_REPLACE, 4'd0, 64'd3, 1'b1);

    for (int unsigned ph = 0; ph < 9; ph++) begin
      write_active(phase_cfg[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 86;
        default: idle_pct = 32;
      endcase
      items_left = 195;
      while (items_left > 0) merge_round();
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (24) @(posedge clk);
    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, settings_used, checked);
    $display("idling: none, sender 86 in 100, sender 32 in 100; drains before each setting");
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
